/* rtl/mwrp_pkg.sv */
`default_nettype none

package mwrp_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = IDX_W + 1;
    localparam int CFG_W       = 5;
    localparam int VAL_W       = 32;
    localparam int PROB_W      = 17;
    localparam int MASK_W      = 16;
    localparam int FRAC_W      = 16;
    localparam int SUM_W       = PROB_W + IDX_W;

    localparam logic [PROB_W-1:0] PROB_ONE = PROB_W'(65536);

    typedef enum logic [1:0] {
        ST_LOADED  = 2'd0,
        ST_SAMPLED = 2'd1,
        ST_EMPTY   = 2'd2
    } t_status;

    typedef struct packed {
        logic             wr_en;     // store the accepted load beat
        logic             start;     // latch a sample beat, clear accumulators
        logic             rd_en;
        logic             rd_pass2;  // read belongs to the cumulative walk
        logic [IDX_W-1:0] rd_addr;
        logic             mult;      // register the scaled threshold
        logic             load_out;
        t_status          out_kind;
    } t_cmd;

    typedef struct packed {
        logic [CNT_W-1:0] count;     // capped entry count of the current sample
        logic             empty;     // nothing selectable after the first pass
    } t_sts;

endpackage

`default_nettype wire

/* rtl/mwrp_if.sv */
`default_nettype none

interface mwrp_in_if;
    logic                           valid;
    logic                           ready;
    logic                           mode;
    logic [mwrp_pkg::IDX_W-1:0]     entry_index;
    logic signed [mwrp_pkg::VAL_W-1:0] entry_value;
    logic [mwrp_pkg::PROB_W-1:0]    entry_probability;
    logic [mwrp_pkg::MASK_W-1:0]    excluded_mask;
    logic [mwrp_pkg::FRAC_W-1:0]    random_fraction;

    modport source (output valid, mode, entry_index, entry_value, entry_probability,
                    excluded_mask, random_fraction, input ready);
    modport sink   (input valid, mode, entry_index, entry_value, entry_probability,
                    excluded_mask, random_fraction, output ready);
endinterface

interface mwrp_out_if;
    logic                              valid;
    logic                              ready;
    logic [1:0]                        status;
    logic [mwrp_pkg::IDX_W-1:0]        chosen_index;
    logic signed [mwrp_pkg::VAL_W-1:0] chosen_value;
    logic [mwrp_pkg::PROB_W-1:0]       chosen_probability;

    modport source (output valid, status, chosen_index, chosen_value, chosen_probability,
                    input ready);
    modport sink   (input valid, status, chosen_index, chosen_value, chosen_probability,
                    output ready);
endinterface

interface mwrp_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [mwrp_pkg::CFG_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

/* rtl/masked_weighted_random_pick.sv */
// Channel  Dir  Handshake      Payload
// i_in     in   valid / ready  mode, entry_index, entry_value, entry_probability,
//                              excluded_mask, random_fraction
// o_out    out  valid / ready  status, chosen_index, chosen_value, chosen_probability
// i_cfg    in   valid / ready  data (entry_count)
//
// A load beat is written into the table and then reported from the output register; a
// sample beat takes two walks over the single read port of the table, one entry per
// cycle, over the N entries in use; the second walk is skipped when nothing is selectable.
// One beat is worked on at a time; a new beat is taken while the last result
// still waits in the output register, and the next result holds until it is taken.
// Reset is synchronous, active low; the table is not cleared and entry_count
// returns to 1. The config port never stalls.
`default_nettype none

module masked_weighted_random_pick (
    input  logic    i_clk,
    input  logic    i_rst_n,
    mwrp_in_if.sink   i_in,
    mwrp_out_if.source o_out,
    mwrp_cfg_if.sink  i_cfg
);
    import mwrp_pkg::*;

    t_cmd cmd;
    t_sts sts;

    mwrp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_mode   (i_in.mode),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    mwrp_dp u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_valid          (i_cfg.valid),
        .i_cfg_data           (i_cfg.data),
        .o_cfg_ready          (i_cfg.ready),
        .i_entry_index        (i_in.entry_index),
        .i_entry_value        (i_in.entry_value),
        .i_entry_probability  (i_in.entry_probability),
        .i_excluded_mask      (i_in.excluded_mask),
        .i_random_fraction    (i_in.random_fraction),
        .i_cmd                (cmd),
        .o_sts                (sts),
        .o_status             (o_out.status),
        .o_chosen_index       (o_out.chosen_index),
        .o_chosen_value       (o_out.chosen_value),
        .o_chosen_probability (o_out.chosen_probability)
    );

endmodule

`default_nettype wire

/* rtl/mwrp_ctrl.sv */
`default_nettype none

module mwrp_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_mode,
    output logic           o_in_ready,
    input  logic           i_out_ready,
    output logic           o_out_valid,
    output mwrp_pkg::t_cmd o_cmd,
    input  mwrp_pkg::t_sts i_sts
);
    import mwrp_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PASS1,
        S_WAIT1,
        S_PASS2,
        S_WAIT2,
        S_DONE
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_idx, n_idx;
    t_status          r_kind, n_kind;
    logic             r_out_valid, n_out_valid;

    always_comb begin
        n_state          = r_state;
        n_idx            = r_idx;
        n_kind           = r_kind;
        o_cmd            = '0;
        o_cmd.rd_addr    = r_idx[IDX_W-1:0];
        o_cmd.out_kind   = r_kind;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (!i_in_mode) begin
                        o_cmd.wr_en = 1'b1;
                        n_kind      = ST_LOADED;
                        n_state     = S_DONE;
                    end else begin
                        o_cmd.start = 1'b1;
                        n_idx       = '0;
                        n_state     = S_PASS1;
                    end
                end
            end
            S_PASS1: begin
                if (r_idx < i_sts.count) begin
                    o_cmd.rd_en = 1'b1;
                    n_idx       = r_idx + CNT_W'(1);
                end else begin
                    n_state = S_WAIT1;
                end
            end
            S_WAIT1: begin
                if (i_sts.empty) begin
                    n_kind  = ST_EMPTY;
                    n_state = S_DONE;
                end else begin
                    o_cmd.mult = 1'b1;
                    n_idx      = '0;
                    n_state    = S_PASS2;
                end
            end
            S_PASS2: begin
                if (r_idx < i_sts.count) begin
                    o_cmd.rd_en    = 1'b1;
                    o_cmd.rd_pass2 = 1'b1;
                    n_idx          = r_idx + CNT_W'(1);
                end else begin
                    n_state = S_WAIT2;
                end
            end
            S_WAIT2: begin
                n_kind  = ST_SAMPLED;
                n_state = S_DONE;
            end
            S_DONE: begin
                // hold here until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_out_valid = o_cmd.load_out | (r_out_valid & ~i_out_ready);
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_kind      <= ST_LOADED;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_kind      <= n_kind;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

/* rtl/mwrp_dp.sv */
`default_nettype none

module mwrp_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    input  logic [mwrp_pkg::CFG_W-1:0]           i_cfg_data,
    output logic                                 o_cfg_ready,
    input  logic [mwrp_pkg::IDX_W-1:0]           i_entry_index,
    input  logic signed [mwrp_pkg::VAL_W-1:0]    i_entry_value,
    input  logic [mwrp_pkg::PROB_W-1:0]          i_entry_probability,
    input  logic [mwrp_pkg::MASK_W-1:0]          i_excluded_mask,
    input  logic [mwrp_pkg::FRAC_W-1:0]          i_random_fraction,
    input  mwrp_pkg::t_cmd                       i_cmd,
    output mwrp_pkg::t_sts                       o_sts,
    output logic [1:0]                           o_status,
    output logic [mwrp_pkg::IDX_W-1:0]           o_chosen_index,
    output logic signed [mwrp_pkg::VAL_W-1:0]    o_chosen_value,
    output logic [mwrp_pkg::PROB_W-1:0]          o_chosen_probability
);
    import mwrp_pkg::*;

    logic [VAL_W-1:0]  r_vals  [MAX_ENTRIES];
    logic [PROB_W-1:0] r_probs [MAX_ENTRIES];

    logic [CFG_W-1:0]  r_entry_count;
    logic [CNT_W-1:0]  r_count;
    logic [MASK_W-1:0] r_mask;
    logic [FRAC_W-1:0] r_frac;

    logic              r_rd_vld;
    logic              r_rd_pass2;
    logic [IDX_W-1:0]  r_rd_idx;
    logic [VAL_W-1:0]  r_rd_val;
    logic [PROB_W-1:0] r_rd_prob;

    logic [SUM_W-1:0]  r_excl;
    logic              r_have_last;
    logic [IDX_W-1:0]  r_last;
    logic [PROB_W-1:0] r_thresh;
    logic [SUM_W-1:0]  r_acc;
    logic              r_found;
    logic [IDX_W-1:0]  r_sel_idx;
    logic [VAL_W-1:0]  r_sel_val;
    logic [PROB_W-1:0] r_sel_prob;
    logic [VAL_W-1:0]  r_last_val;
    logic [PROB_W-1:0] r_last_prob;

    logic [1:0]        r_out_status;
    logic [IDX_W-1:0]  r_out_idx;
    logic [VAL_W-1:0]  r_out_val;
    logic [PROB_W-1:0] r_out_prob;

    logic [PROB_W-1:0]        wr_prob;
    logic [CNT_W-1:0]         cap_count;
    logic                     rd_excluded;
    logic [SUM_W-1:0]         acc_sum;
    logic [PROB_W-1:0]        remaining;
    logic [FRAC_W+PROB_W-1:0] product;

    function automatic logic [SUM_W-1:0] acc_excl(input logic [SUM_W-1:0]  sum,
                                                  input logic [PROB_W-1:0] p);
        acc_excl = sum + SUM_W'(p);
    endfunction

    assign o_cfg_ready = 1'b1;

    assign wr_prob   = (i_entry_probability > PROB_ONE) ? PROB_ONE : i_entry_probability;
    assign cap_count = (r_entry_count > CFG_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES)
                                                             : CNT_W'(r_entry_count);
    assign rd_excluded = r_mask[r_rd_idx];
    assign acc_sum     = r_acc + SUM_W'(r_rd_prob);
    assign remaining   = PROB_W'(SUM_W'(PROB_ONE) - r_excl);
    assign product     = r_frac * remaining;

    assign o_sts.count = r_count;
    assign o_sts.empty = !r_have_last || (r_excl >= SUM_W'(PROB_ONE));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= CFG_W'(1);
        end else if (i_cfg_valid) begin
            r_entry_count <= i_cfg_data;
        end
    end

    // table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_vals[i_entry_index]  <= i_entry_value;
            r_probs[i_entry_index] <= wr_prob;
        end
        r_rd_val  <= r_vals[i_cmd.rd_addr];
        r_rd_prob <= r_probs[i_cmd.rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_pass2 <= i_cmd.rd_pass2;
        r_rd_idx   <= i_cmd.rd_addr;

        if (i_cmd.start) begin
            r_count     <= cap_count;
            r_mask      <= i_excluded_mask;
            r_frac      <= i_random_fraction;
            r_excl      <= '0;
            r_have_last <= 1'b0;
            r_last      <= '0;
            r_acc       <= '0;
            r_found     <= 1'b0;
        end

        if (i_cmd.mult) begin
            r_thresh <= product[FRAC_W +: PROB_W];
        end

        if (r_rd_vld && !r_rd_pass2) begin
            if (rd_excluded) begin
                r_excl <= acc_excl(r_excl, r_rd_prob);
            end else begin
                r_have_last <= 1'b1;
                r_last      <= r_rd_idx;
            end
        end

        if (r_rd_vld && r_rd_pass2 && !rd_excluded) begin
            r_acc <= acc_sum;
            // keep only the first entry whose running sum reaches the threshold
            if (!r_found && (SUM_W'(r_thresh) <= acc_sum)) begin
                r_found    <= 1'b1;
                r_sel_idx  <= r_rd_idx;
                r_sel_val  <= r_rd_val;
                r_sel_prob <= r_rd_prob;
            end
            if (r_rd_idx == r_last) begin
                r_last_val  <= r_rd_val;
                r_last_prob <= r_rd_prob;
            end
        end

        if (i_cmd.load_out) begin
            r_out_status <= i_cmd.out_kind;
            case (i_cmd.out_kind)
                ST_SAMPLED: begin
                    r_out_idx  <= r_found ? r_sel_idx  : r_last;
                    r_out_val  <= r_found ? r_sel_val  : r_last_val;
                    r_out_prob <= r_found ? r_sel_prob : r_last_prob;
                end
                default: begin
                    r_out_idx  <= '0;
                    r_out_val  <= '0;
                    r_out_prob <= '0;
                end
            endcase
        end
    end

    assign o_status             = r_out_status;
    assign o_chosen_index       = r_out_idx;
    assign o_chosen_value       = r_out_val;
    assign o_chosen_probability = r_out_prob;

endmodule

`default_nettype wire

/* rtl/mwrp_checker.sv */
`default_nettype none

module mwrp_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              i_in_ready,
    input logic                              i_out_valid,
    input logic                              i_out_ready,
    input logic [1:0]                        i_status,
    input logic [mwrp_pkg::IDX_W-1:0]        i_chosen_index,
    input logic [mwrp_pkg::VAL_W-1:0]        i_chosen_value,
    input logic [mwrp_pkg::PROB_W-1:0]       i_chosen_probability
);
    import mwrp_pkg::*;

    // result waits until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status)
                                        && $stable(i_chosen_value))
        else $error("result changed or dropped while stalled");

    // one beat at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input accepted again before the last beat finished");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_status == ST_LOADED) || (i_status == ST_SAMPLED)
                        || (i_status == ST_EMPTY))
        else $error("undefined status code");

    a_zero_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && ((i_status == ST_LOADED) || (i_status == ST_EMPTY))
        |-> (i_chosen_index == '0) && (i_chosen_value == '0)
            && (i_chosen_probability == '0))
        else $error("load or empty result with nonzero payload");

    a_prob_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_chosen_probability <= PROB_ONE))
        else $error("chosen probability above one");

endmodule

bind masked_weighted_random_pick mwrp_checker u_mwrp_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .i_in_valid           (i_in.valid),
    .i_in_ready           (i_in.ready),
    .i_out_valid          (o_out.valid),
    .i_out_ready          (o_out.ready),
    .i_status             (o_out.status),
    .i_chosen_index       (o_out.chosen_index),
    .i_chosen_value       (o_out.chosen_value),
    .i_chosen_probability (o_out.chosen_probability)
);

`default_nettype wire
